/* sv/bmg_pkg.sv */
// ----------------------------------------------------------------------------
// bmg_pkg: shared types and constants of the battery median gauge
// Operating state codes, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bmg_pkg;

    // default sizing of the sample history
    localparam int HISTORY_LEN_DEF = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int VBAT_BITS  = 16;
    localparam int LEVEL_BITS = 16;
    localparam int CAP_BITS   = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_THR    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REDUCED_THR = 2'd1;

    // threshold reset values in millivolts
    localparam logic [LEVEL_BITS-1:0] FULL_THR_RST    = 16'd2750;
    localparam logic [LEVEL_BITS-1:0] REDUCED_THR_RST = 16'd2500;

    // operating state
    typedef enum logic [1:0] {
        ST_UNDEF    = 2'd0,
        ST_FULL     = 2'd1,
        ST_REDUCED  = 2'd2,
        ST_CRITICAL = 2'd3
    } t_app_state;

    // state and capacity derived from one level
    typedef struct packed {
        t_app_state          state;
        logic [CAP_BITS-1:0] capacity;
    } t_gauge;

endpackage

`default_nettype wire

/* sv/bmg_median.sv */
// ----------------------------------------------------------------------------
// bmg_median: median of the sample history
// Ranks every entry against all others (ties broken by position) and
// averages the two middle ranks; for an odd depth both are the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bmg_median
    import bmg_pkg::*;
#(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic [SAMPLE_BITS-1:0] i_samples [HISTORY_LEN],
    output logic      [SAMPLE_BITS-1:0] o_median
);

    localparam int RANK_BITS = $clog2(HISTORY_LEN);
    localparam int LO_RANK   = (HISTORY_LEN - 1) / 2;
    localparam int HI_RANK   = HISTORY_LEN / 2;

    logic [RANK_BITS-1:0]   rank [HISTORY_LEN];
    logic [SAMPLE_BITS-1:0] lo_val;
    logic [SAMPLE_BITS-1:0] hi_val;
    logic [SAMPLE_BITS:0]   mid_sum;

    // rank of each entry: count of entries that sort ahead of it
    always_comb begin
        for (int i = 0; i < HISTORY_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < HISTORY_LEN; j++) begin
                if (j != i) begin
                    if ((i_samples[j] < i_samples[i]) ||
                        ((i_samples[j] == i_samples[i]) && (j < i))) begin
                        rank[i] = rank[i] + RANK_BITS'(1);
                    end
                end
            end
        end
    end

    // pick the two middle ranks, ranks are unique
    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < HISTORY_LEN; i++) begin
            if (rank[i] == RANK_BITS'(LO_RANK)) begin
                lo_val = lo_val | i_samples[i];
            end
            if (rank[i] == RANK_BITS'(HI_RANK)) begin
                hi_val = hi_val | i_samples[i];
            end
        end
    end

    // floor of the mean of the middle pair
    assign mid_sum  = {1'b0, lo_val} + {1'b0, hi_val};
    assign o_median = mid_sum[SAMPLE_BITS:1];

endmodule

`default_nettype wire

/* sv/bmg_gauge.sv */
// ----------------------------------------------------------------------------
// bmg_gauge: operating state and capacity from the filtered level
// Threshold compare, then a piecewise linear percent map with saturation;
// the divisions by 10 and 50 are reciprocal multiplies on the unsaturated range.
// ----------------------------------------------------------------------------
`default_nettype none

module bmg_gauge
    import bmg_pkg::*;
(
    input  wire logic [LEVEL_BITS-1:0] i_level,
    input  wire logic [LEVEL_BITS-1:0] i_full_thr,
    input  wire logic [LEVEL_BITS-1:0] i_reduced_thr,
    output t_gauge                     o_gauge
);

    // full range: (3v - 7995) / 10, saturating at 100 from 1010 up
    localparam logic [17:0] FULL_OFS   = 18'd7995;
    localparam logic [17:0] FULL_SAT   = 18'd1010;
    localparam logic [17:0] FULL_RECIP = 18'd205;      // 2^11 / 10, rounded up
    localparam logic [CAP_BITS-1:0] FULL_MAX = 7'd100;
    // reduced range: (4v - 9475) / 50, saturating at 25 from 1300 up
    localparam logic [17:0] RED_OFS    = 18'd9475;
    localparam logic [17:0] RED_SAT    = 18'd1300;
    localparam logic [21:0] RED_RECIP  = 22'd1311;     // 2^16 / 50, rounded up
    localparam logic [CAP_BITS-1:0] RED_MAX = 7'd25;

    t_app_state  state;
    logic [17:0] x3;
    logic [17:0] d3;
    logic [17:0] p3;
    logic [17:0] x4;
    logic [17:0] d4;
    logic [21:0] p4;
    logic [CAP_BITS-1:0] cap;

    // threshold compare
    always_comb begin
        if (i_level > i_full_thr) begin
            state = ST_FULL;
        end else if (i_level > i_reduced_thr) begin
            state = ST_REDUCED;
        end else begin
            state = ST_CRITICAL;
        end
    end

    // scaled and offset level for both ranges
    assign x3 = 18'(i_level) + {1'b0, i_level, 1'b0};
    assign d3 = x3 - FULL_OFS;
    assign p3 = 18'(d3[9:0]) * FULL_RECIP;
    assign x4 = {i_level, 2'b00};
    assign d4 = x4 - RED_OFS;
    assign p4 = 22'(d4[10:0]) * RED_RECIP;

    // percent map with clamping at both ends
    always_comb begin
        if (state == ST_FULL) begin
            if (x3 < FULL_OFS) begin
                cap = '0;
            end else if (d3 >= FULL_SAT) begin
                cap = FULL_MAX;
            end else begin
                cap = p3[17:11];
            end
        end else begin
            if (x4 < RED_OFS) begin
                cap = '0;
            end else if (d4 >= RED_SAT) begin
                cap = RED_MAX;
            end else begin
                cap = {2'b00, p4[20:16]};
            end
        end
    end

    assign o_gauge.state    = state;
    assign o_gauge.capacity = cap;

endmodule

`default_nettype wire

/* sv/battery_median_gauge.sv */
// ----------------------------------------------------------------------------
// battery_median_gauge: median filtered battery voltage gauge
// Keeps a ring of voltage samples, takes their median once the ring is full
// and maps it to an operating state and a remaining capacity in percent.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                 payload
//   input     in          i_valid / o_stall         i_command, i_vbat_mv
//   result    out         o_valid / i_stall         history fields, state, capacity
//   config    in          i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result channel is not stalled; each
// item passes the input register, then the ring update and result register.
// The ring update, median, compare and percent map are combinational.
// Reset clears the fill state, stored level, state and capacity and returns
// the thresholds to their defaults; ring entries are not reset and are only
// read once rewritten.
// A stalled result holds; input stalls only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_median_gauge
    import bmg_pkg::*;
#(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input channel
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_command,
    input  wire logic [VBAT_BITS-1:0]     i_vbat_mv,
    // result channel
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_history_ready,
    output logic [LEVEL_BITS-1:0]         o_median_mv,
    output logic [1:0]                    o_app_state,
    output logic [1:0]                    o_previous_state,
    output logic                          o_state_changed,
    output logic [CAP_BITS-1:0]           o_capacity_pct,
    output logic                          o_capacity_changed,
    // configuration channel
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SLOT_BITS = $clog2(HISTORY_LEN);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(HISTORY_LEN - 1);

    // input register
    logic                   r_in_valid;
    logic                   r_in_cmd;
    logic [VBAT_BITS-1:0]   r_in_vbat;
    // history and stored gauge state
    logic [SAMPLE_BITS-1:0] r_ring [HISTORY_LEN];
    logic [SLOT_BITS-1:0]   r_slot;
    logic                   r_filled;
    logic [LEVEL_BITS-1:0]  r_level;
    t_app_state             r_state;
    logic [CAP_BITS-1:0]    r_cap;
    // thresholds
    logic [LEVEL_BITS-1:0]  r_full_thr;
    logic [LEVEL_BITS-1:0]  r_reduced_thr;
    // result register
    logic                   r_out_valid;
    logic                   r_out_ready;
    logic [LEVEL_BITS-1:0]  r_out_level;
    t_app_state             r_out_state;
    t_app_state             r_out_prev;
    logic                   r_out_state_chg;
    logic [CAP_BITS-1:0]    r_out_cap;
    logic                   r_out_cap_chg;

    logic                   advance;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SLOT_BITS-1:0]   wr_slot;
    logic [SAMPLE_BITS-1:0] n_ring [HISTORY_LEN];
    logic [SLOT_BITS-1:0]   n_slot;
    logic                   n_filled;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] median;
    logic [LEVEL_BITS-1:0]  new_level;
    t_gauge                 gauge;
    logic                   cap_chg;

    // handshake: input stage moves on when the result slot frees up
    assign advance     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && r_out_valid && i_stall;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_cmd  <= i_command;
            r_in_vbat <= i_vbat_mv;
        end
    end

    // ring write and fill tracking
    assign sample  = SAMPLE_BITS'(r_in_vbat);
    assign wr_slot = r_in_cmd ? '0 : r_slot;

    always_comb begin
        for (int i = 0; i < HISTORY_LEN; i++) begin
            n_ring[i] = (wr_slot == SLOT_BITS'(i)) ? sample : r_ring[i];
        end
    end

    always_comb begin
        if (r_in_cmd) begin
            n_slot   = SLOT_BITS'(1);
            n_filled = 1'b0;
        end else if (r_slot == LAST_SLOT) begin
            n_slot   = '0;
            n_filled = 1'b1;
        end else begin
            n_slot   = r_slot + SLOT_BITS'(1);
            n_filled = r_filled;
        end
    end

    assign ready = !r_in_cmd && n_filled;

    // median over the updated ring
    bmg_median #(
        .HISTORY_LEN (HISTORY_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .i_samples (n_ring),
        .o_median  (median)
    );

    assign new_level = LEVEL_BITS'(median);

    // state and capacity from the new level
    bmg_gauge u_gauge (
        .i_level       (new_level),
        .i_full_thr    (r_full_thr),
        .i_reduced_thr (r_reduced_thr),
        .o_gauge       (gauge)
    );

    assign cap_chg = ready && (gauge.capacity != r_cap);

    // ring entries, written only
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ring[wr_slot] <= sample;
        end
    end

    // stored gauge state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_filled <= 1'b0;
            r_level  <= '0;
            r_state  <= ST_UNDEF;
            r_cap    <= '0;
        end else if (advance) begin
            r_slot   <= n_slot;
            r_filled <= n_filled;
            if (ready) begin
                r_level <= new_level;
                r_state <= gauge.state;
                r_cap   <= gauge.capacity;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_thr    <= FULL_THR_RST;
            r_reduced_thr <= REDUCED_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FULL_THR:    r_full_thr    <= LEVEL_BITS'(i_cfg_data);
                CFG_REDUCED_THR: r_reduced_thr <= LEVEL_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload, stored values while the ring fills
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ready     <= ready;
            r_out_cap_chg   <= cap_chg;
            if (ready) begin
                r_out_level     <= new_level;
                r_out_state     <= gauge.state;
                r_out_prev      <= r_state;
                r_out_state_chg <= (gauge.state != r_state);
                r_out_cap       <= gauge.capacity;
            end else begin
                r_out_level     <= r_level;
                r_out_state     <= r_state;
                r_out_prev      <= r_state;
                r_out_state_chg <= 1'b0;
                r_out_cap       <= r_cap;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_history_ready    = r_out_ready;
    assign o_median_mv        = r_out_level;
    assign o_app_state        = r_out_state;
    assign o_previous_state   = r_out_prev;
    assign o_state_changed    = r_out_state_chg;
    assign o_capacity_pct     = r_out_cap;
    assign o_capacity_changed = r_out_cap_chg;

endmodule

`default_nettype wire

/* sv/bmg_checker.sv */
// ----------------------------------------------------------------------------
// bmg_checker: port level checks of the battery median gauge
// Watches the result channel for holding under stall and consistent flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bmg_checker
    import bmg_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic                     o_history_ready,
    input wire logic [1:0]               o_app_state,
    input wire logic [1:0]               o_previous_state,
    input wire logic                     o_state_changed,
    input wire logic [CAP_BITS-1:0]      o_capacity_pct,
    input wire logic                     o_capacity_changed
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // while the ring fills nothing is reported as changed
    a_not_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_history_ready) |->
        (!o_state_changed && !o_capacity_changed && o_previous_state == o_app_state))
        else $error("change reported without full history");

    // state change flag agrees with the two states shown
    a_state_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_history_ready) |->
        (o_state_changed == (o_app_state != o_previous_state)))
        else $error("state change flag inconsistent");

    // a computed result always has a defined state
    a_state_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_history_ready) |-> (o_app_state != ST_UNDEF))
        else $error("undefined state with full history");

    // capacity stays a percentage
    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_capacity_pct <= 7'd100))
        else $error("capacity above 100 percent");

endmodule

bind battery_median_gauge bmg_checker u_bmg_checker (.*);

`default_nettype wire
